/* sv/cwc_pkg.sv */
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared widths, register indexes and the frame totals record for the
// colour window centroid block.
// ----------------------------------------------------------------------------
package cwc_pkg;

    // field widths
    localparam int PIXEL_W     = 8;
    localparam int COORD_W     = 11;
    localparam int SUM_W       = 33;
    localparam int COUNT_W     = 23;
    localparam int QUOT_W      = COORD_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // image extent, pixels at or beyond it never match
    localparam int MAX_COLUMNS = 2048;
    localparam int MAX_ROWS    = 2048;

    // frame totals waiting between the accumulator and the divider
    localparam int QUEUE_DEPTH = 2;

    // reset values of the bound registers
    localparam logic [CFG_DATA_W-1:0] BLUE_LOW_RST   = 8'd20;
    localparam logic [CFG_DATA_W-1:0] BLUE_HIGH_RST  = 8'd50;
    localparam logic [CFG_DATA_W-1:0] GREEN_LOW_RST  = 8'd100;
    localparam logic [CFG_DATA_W-1:0] GREEN_HIGH_RST = 8'd130;
    localparam logic [CFG_DATA_W-1:0] RED_LOW_RST    = 8'd100;
    localparam logic [CFG_DATA_W-1:0] RED_HIGH_RST   = 8'd130;

    // register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BLUE_LOW   = 3'd0,
        REG_BLUE_HIGH  = 3'd1,
        REG_GREEN_LOW  = 3'd2,
        REG_GREEN_HIGH = 3'd3,
        REG_RED_LOW    = 3'd4,
        REG_RED_HIGH   = 3'd5
    } cfg_reg_t;

    // totals of one finished frame
    typedef struct packed {
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
        logic [COUNT_W-1:0] count;
        logic               bad;
    } frame_totals_t;

endpackage

/* sv/cwc_front.sv */
// ----------------------------------------------------------------------------
// cwc_front
// Bound registers, pixel classification and running sums; hands the totals
// of each frame on at its last pixel.
// ----------------------------------------------------------------------------
module cwc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [cwc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cwc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              pix_accept,
    input  logic [cwc_pkg::PIXEL_W-1:0]       blue_value,
    input  logic [cwc_pkg::PIXEL_W-1:0]       green_value,
    input  logic [cwc_pkg::PIXEL_W-1:0]       red_value,
    input  logic [cwc_pkg::COORD_W-1:0]       pixel_x,
    input  logic [cwc_pkg::COORD_W-1:0]       pixel_y,
    input  logic                              frame_end,
    output logic                              totals_push,
    output cwc_pkg::frame_totals_t            totals
);
    import cwc_pkg::*;

    logic [CFG_DATA_W-1:0] blue_low_reg, blue_high_reg;
    logic [CFG_DATA_W-1:0] green_low_reg, green_high_reg;
    logic [CFG_DATA_W-1:0] red_low_reg, red_high_reg;

    logic [SUM_W-1:0]   sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]   sum_y_reg, sum_y_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [SUM_W:0]     sum_x_ext, sum_y_ext;
    logic [SUM_W-1:0]   sum_x_upd, sum_y_upd;
    logic [COUNT_W-1:0] count_upd;
    logic               colour_hit, in_image, take;

    // bound registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blue_low_reg   <= BLUE_LOW_RST;
            blue_high_reg  <= BLUE_HIGH_RST;
            green_low_reg  <= GREEN_LOW_RST;
            green_high_reg <= GREEN_HIGH_RST;
            red_low_reg    <= RED_LOW_RST;
            red_high_reg   <= RED_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BLUE_LOW:   blue_low_reg   <= cfg_data;
                REG_BLUE_HIGH:  blue_high_reg  <= cfg_data;
                REG_GREEN_LOW:  green_low_reg  <= cfg_data;
                REG_GREEN_HIGH: green_high_reg <= cfg_data;
                REG_RED_LOW:    red_low_reg    <= cfg_data;
                REG_RED_HIGH:   red_high_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // strict window test on every channel and image extent
    assign colour_hit = (blue_value  > blue_low_reg)  && (blue_value  < blue_high_reg)  &&
                        (green_value > green_low_reg) && (green_value < green_high_reg) &&
                        (red_value   > red_low_reg)   && (red_value   < red_high_reg);
    assign in_image   = ({21'd0, pixel_x} < 32'(MAX_COLUMNS)) &&
                        ({21'd0, pixel_y} < 32'(MAX_ROWS));

    // accumulate unless a sum or the count would overflow
    assign sum_x_ext = {1'b0, sum_x_reg} + (SUM_W+1)'(pixel_x);
    assign sum_y_ext = {1'b0, sum_y_reg} + (SUM_W+1)'(pixel_y);
    assign take      = colour_hit && in_image && !(&count_reg) &&
                       !sum_x_ext[SUM_W] && !sum_y_ext[SUM_W];

    assign sum_x_upd = take ? sum_x_ext[SUM_W-1:0] : sum_x_reg;
    assign sum_y_upd = take ? sum_y_ext[SUM_W-1:0] : sum_y_reg;
    assign count_upd = take ? count_reg + COUNT_W'(1) : count_reg;

    // clear after the last pixel of a frame
    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        count_next = count_reg;
        if (pix_accept)
        begin
            sum_x_next = frame_end ? '0 : sum_x_upd;
            sum_y_next = frame_end ? '0 : sum_y_upd;
            count_next = frame_end ? '0 : count_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            count_reg <= count_next;
        end
    end

    // frame totals towards the divider
    assign totals_push  = pix_accept && frame_end;
    assign totals.sum_x = sum_x_upd;
    assign totals.sum_y = sum_y_upd;
    assign totals.count = count_upd;
    assign totals.bad   = (blue_low_reg  > blue_high_reg)  ||
                          (green_low_reg > green_high_reg) ||
                          (red_low_reg   > red_high_reg);

endmodule

/* sv/cwc_queue.sv */
// ----------------------------------------------------------------------------
// cwc_queue
// Short queue of frame totals between the accumulator and the divider.
// ----------------------------------------------------------------------------
module cwc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cwc_pkg::frame_totals_t push_data,
    output logic                   q_full,
    input  logic                   pull,
    output cwc_pkg::frame_totals_t pull_data,
    output logic                   q_empty
);
    import cwc_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    frame_totals_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic                 do_push, do_pull;

    assign q_full    = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign q_empty   = (fill_reg == '0);
    assign do_push   = push && !q_full;
    assign do_pull   = pull && !q_empty;
    assign pull_data = entry_reg[rd_ptr_reg];

    // storage, written at the tail
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pull)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pull)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (do_pull && !do_push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

endmodule

/* sv/cwc_back.sv */
// ----------------------------------------------------------------------------
// cwc_back
// Restoring divider for both centroid coordinates, one quotient bit per
// cycle, and the result register.
// ----------------------------------------------------------------------------
module cwc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          totals_empty,
    input  cwc_pkg::frame_totals_t        totals,
    output logic                          totals_pull,
    input  logic                          pop,
    output logic                          empty,
    output logic                          target_found,
    output logic [cwc_pkg::COORD_W-1:0]   center_x,
    output logic [cwc_pkg::COORD_W-1:0]   center_y,
    output logic [cwc_pkg::COUNT_W-1:0]   match_count,
    output logic                          bounds_invalid
);
    import cwc_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    rem_x_reg, rem_y_reg, div_reg;
    logic [QUOT_W-1:0]   quot_x_reg, quot_y_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                bad_reg;
    logic                out_valid_reg;
    logic                found_reg;
    logic [COORD_W-1:0]  center_x_reg, center_y_reg;
    logic [COUNT_W-1:0]  match_count_reg;
    logic                bounds_invalid_reg;

    logic                ge_x, ge_y, slot_free, load_result;

    // one trial subtraction per coordinate
    assign ge_x        = (rem_x_reg >= div_reg);
    assign ge_y        = (rem_y_reg >= div_reg);
    assign slot_free   = !out_valid_reg || pop;
    assign load_result = (state_reg == ST_HOLD) && slot_free;

    assign totals_pull = (state_reg == ST_IDLE) && !totals_empty;

    // sequencer, datapath and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            step_reg           <= '0;
            rem_x_reg          <= '0;
            rem_y_reg          <= '0;
            div_reg            <= '0;
            quot_x_reg         <= '0;
            quot_y_reg         <= '0;
            count_reg          <= '0;
            bad_reg            <= 1'b0;
            out_valid_reg      <= 1'b0;
            found_reg          <= 1'b0;
            center_x_reg       <= '0;
            center_y_reg       <= '0;
            match_count_reg    <= '0;
            bounds_invalid_reg <= 1'b0;
        end
        else
        begin
            // result register occupancy
            if (load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!totals_empty)
                    begin
                        rem_x_reg <= totals.sum_x;
                        rem_y_reg <= totals.sum_y;
                        div_reg   <= SUM_W'({totals.count, {(QUOT_W-1){1'b0}}});
                        count_reg <= totals.count;
                        bad_reg   <= totals.bad;
                        step_reg  <= STEP_W'(QUOT_W - 1);
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (ge_x)
                    begin
                        rem_x_reg <= rem_x_reg - div_reg;
                    end
                    if (ge_y)
                    begin
                        rem_y_reg <= rem_y_reg - div_reg;
                    end
                    quot_x_reg <= {quot_x_reg[QUOT_W-2:0], ge_x};
                    quot_y_reg <= {quot_y_reg[QUOT_W-2:0], ge_y};
                    div_reg    <= div_reg >> 1;
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_HOLD;
                    end
                    else
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                end
                ST_HOLD:
                begin
                    // no match means the quotient is meaningless
                    if (slot_free)
                    begin
                        found_reg          <= (count_reg != '0);
                        center_x_reg       <= (count_reg != '0) ? quot_x_reg : '0;
                        center_y_reg       <= (count_reg != '0) ? quot_y_reg : '0;
                        match_count_reg    <= count_reg;
                        bounds_invalid_reg <= bad_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign empty          = !out_valid_reg;
    assign target_found   = found_reg;
    assign center_x       = center_x_reg;
    assign center_y       = center_y_reg;
    assign match_count    = match_count_reg;
    assign bounds_invalid = bounds_invalid_reg;

endmodule

/* sv/color_window_centroid.sv */
// ----------------------------------------------------------------------------
// color_window_centroid
// Colour window blob centroid: counts pixels inside per-channel bounds and
// gives the mean position of the matches at the end of each frame.
// ----------------------------------------------------------------------------
//  channel   handshake             contents
//  pixel     push / full           blue, green, red, x, y, frame_end
//  result    empty / pop           found, centre x/y, count, bounds flag
//  config    cfg_write (no wait)   cfg_index selects bound, cfg_data
//
//  One pixel per clock is taken while full is low; each request is
//  classified and summed in the cycle it is accepted.
//  With the divider free, the totals of a frame, once its last pixel's
//  request is accepted, pass through the queue into the divider, through
//  eleven divide steps of one quotient bit each and into the result
//  register; an unpopped result holds the divider back. Two finished frames
//  can wait ahead of the divider; full rises while both slots are taken.
//  Reset restores the default bounds.
// ----------------------------------------------------------------------------
module color_window_centroid (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [cwc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cwc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [cwc_pkg::PIXEL_W-1:0]       blue_value,
    input  logic [cwc_pkg::PIXEL_W-1:0]       green_value,
    input  logic [cwc_pkg::PIXEL_W-1:0]       red_value,
    input  logic [cwc_pkg::COORD_W-1:0]       pixel_x,
    input  logic [cwc_pkg::COORD_W-1:0]       pixel_y,
    input  logic                              frame_end,
    output logic                              empty,
    input  logic                              pop,
    output logic                              target_found,
    output logic [cwc_pkg::COORD_W-1:0]       center_x,
    output logic [cwc_pkg::COORD_W-1:0]       center_y,
    output logic [cwc_pkg::COUNT_W-1:0]       match_count,
    output logic                              bounds_invalid
);
    import cwc_pkg::*;

    logic          pix_accept;
    logic          totals_push, totals_pull, totals_empty;
    frame_totals_t front_totals, back_totals;

    assign pix_accept = push && !full;

    // classification and accumulation
    cwc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_accept  (pix_accept),
        .blue_value  (blue_value),
        .green_value (green_value),
        .red_value   (red_value),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .frame_end   (frame_end),
        .totals_push (totals_push),
        .totals      (front_totals)
    );

    // frame totals waiting for the divider
    cwc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (totals_push),
        .push_data (front_totals),
        .q_full    (full),
        .pull      (totals_pull),
        .pull_data (back_totals),
        .q_empty   (totals_empty)
    );

    // division and result register
    cwc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .totals_empty   (totals_empty),
        .totals         (back_totals),
        .totals_pull    (totals_pull),
        .pop            (pop),
        .empty          (empty),
        .target_found   (target_found),
        .center_x       (center_x),
        .center_y       (center_y),
        .match_count    (match_count),
        .bounds_invalid (bounds_invalid)
    );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the colour window centroid block. A directed table
// of pixels at the default bounds comes first, then several bound settings
// (open, reversed, equal, narrow, random) each driven with random frames.
// A local centroid predictor yields the expected frame results, which are
// compared field by field with what the block pops out.
// ----------------------------------------------------------------------------
module testbench;
    import cwc_pkg::*;

    localparam int NUM_BOUNDS     = 6;
    localparam int DIRECTED_ROWS  = 21;
    localparam int PHASES         = 10;
    localparam int PHASE_PIXELS   = 165;
    localparam int QUIET_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // indexes beyond the bound registers, writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    localparam logic [SUM_W:0]     SUM_LIMIT   = {1'b0, {SUM_W{1'b1}}};
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [PIXEL_W-1:0] blue;
        logic [PIXEL_W-1:0] green;
        logic [PIXEL_W-1:0] red;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } pixel_t;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COUNT_W-1:0] count;
        logic               invalid;
    } centroid_t;

    typedef struct packed {
        pixel_t    pix;
        logic      typed;
        centroid_t want;
    } directed_row_t;

    typedef logic [CFG_DATA_W-1:0] bound_set_t [NUM_BOUNDS];

    localparam centroid_t EMPTY_FRAME = '0;

    // dut ports
    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   cfg_write   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   push        = 1'b0;
    logic                   full;
    logic [PIXEL_W-1:0]     blue_value  = '0;
    logic [PIXEL_W-1:0]     green_value = '0;
    logic [PIXEL_W-1:0]     red_value   = '0;
    logic [COORD_W-1:0]     pixel_x     = '0;
    logic [COORD_W-1:0]     pixel_y     = '0;
    logic                   frame_end   = 1'b0;
    logic                   empty;
    logic                   pop         = 1'b0;
    logic                   target_found;
    logic [COORD_W-1:0]     center_x;
    logic [COORD_W-1:0]     center_y;
    logic [COUNT_W-1:0]     match_count;
    logic                   bounds_invalid;

    // predictor state and bench bookkeeping
    bound_set_t         bound_copy = '{BLUE_LOW_RST, BLUE_HIGH_RST, GREEN_LOW_RST,
                                       GREEN_HIGH_RST, RED_LOW_RST, RED_HIGH_RST};
    logic [SUM_W-1:0]   sum_x_acc  = '0;
    logic [SUM_W-1:0]   sum_y_acc  = '0;
    logic [COUNT_W-1:0] hits       = '0;
    centroid_t          centroid_due [$];
    logic               steady_flow   = 1'b0;
    int                 mismatches    = 0;
    int                 pixels_sent   = 0;
    int                 results_seen  = 0;
    int                 frames_found  = 0;
    int                 invalid_seen  = 0;
    int                 idle_cycles   = 0;

    // default bounds: blue 20..50, green 100..130, red 100..130 (exclusive)
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // single matching pixel at the far corner, then at the origin
        '{'{8'd21, 8'd101, 8'd101, 11'd2047, 11'd2047, 1'b1}, 1'b1,
          '{1'b1, 11'd2047, 11'd2047, 23'd1, 1'b0}},
        '{'{8'd49, 8'd129, 8'd129, 11'd0, 11'd0, 1'b1}, 1'b1,
          '{1'b1, 11'd0, 11'd0, 23'd1, 1'b0}},
        // each channel sitting exactly on a bound never matches
        '{'{8'd20, 8'd110, 8'd110, 11'd7, 11'd7, 1'b1}, 1'b1, EMPTY_FRAME},
        '{'{8'd50, 8'd110, 8'd110, 11'd7, 11'd7, 1'b1}, 1'b1, EMPTY_FRAME},
        '{'{8'd30, 8'd100, 8'd110, 11'd7, 11'd7, 1'b1}, 1'b1, EMPTY_FRAME},
        '{'{8'd30, 8'd130, 8'd110, 11'd7, 11'd7, 1'b1}, 1'b1, EMPTY_FRAME},
        '{'{8'd30, 8'd110, 8'd100, 11'd7, 11'd7, 1'b1}, 1'b1, EMPTY_FRAME},
        '{'{8'd30, 8'd110, 8'd130, 11'd7, 11'd7, 1'b1}, 1'b1, EMPTY_FRAME},
        // channel extremes
        '{'{8'd255, 8'd255, 8'd255, 11'd2047, 11'd2047, 1'b1}, 1'b1, EMPTY_FRAME},
        '{'{8'd0, 8'd0, 8'd0, 11'd0, 11'd0, 1'b1}, 1'b1, EMPTY_FRAME},
        // three matches, truncated mean 34/3 and 71/3
        '{'{8'd30, 8'd110, 8'd110, 11'd10, 11'd20, 1'b0}, 1'b0, EMPTY_FRAME},
        '{'{8'd31, 8'd111, 8'd111, 11'd11, 11'd21, 1'b0}, 1'b0, EMPTY_FRAME},
        '{'{8'd32, 8'd112, 8'd112, 11'd13, 11'd30, 1'b1}, 1'b1,
          '{1'b1, 11'd11, 11'd23, 23'd3, 1'b0}},
        // non-matching pixel in the middle of a frame
        '{'{8'd40, 8'd120, 8'd120, 11'd1000, 11'd1500, 1'b0}, 1'b0, EMPTY_FRAME},
        '{'{8'd0, 8'd120, 8'd120, 11'd5, 11'd5, 1'b0}, 1'b0, EMPTY_FRAME},
        '{'{8'd40, 8'd120, 8'd120, 11'd1001, 11'd1502, 1'b1}, 1'b0, EMPTY_FRAME},
        // alternating coordinate bits
        '{'{8'd21, 8'd101, 8'd101, 11'd1365, 11'd682, 1'b0}, 1'b0, EMPTY_FRAME},
        '{'{8'd49, 8'd129, 8'd129, 11'd682, 11'd1365, 1'b1}, 1'b0, EMPTY_FRAME},
        // large sums near the top of the coordinate range
        '{'{8'd30, 8'd110, 8'd110, 11'd2047, 11'd2047, 1'b0}, 1'b0, EMPTY_FRAME},
        '{'{8'd30, 8'd110, 8'd110, 11'd2046, 11'd2046, 1'b0}, 1'b0, EMPTY_FRAME},
        '{'{8'd60, 8'd110, 8'd110, 11'd0, 11'd0, 1'b1}, 1'b0, EMPTY_FRAME}
    };

    color_window_centroid dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .blue_value     (blue_value),
        .green_value    (green_value),
        .red_value      (red_value),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .frame_end      (frame_end),
        .empty          (empty),
        .pop            (pop),
        .target_found   (target_found),
        .center_x       (center_x),
        .center_y       (center_y),
        .match_count    (match_count),
        .bounds_invalid (bounds_invalid)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // strict window test on one channel
    function automatic logic in_window(input logic [PIXEL_W-1:0] v,
                                       input logic [CFG_DATA_W-1:0] lo,
                                       input logic [CFG_DATA_W-1:0] hi);
        return v > lo && v < hi;
    endfunction

    // centroid predictor: accumulate one pixel, give the frame result on its end
    function automatic logic centroid_step(input pixel_t p, output centroid_t c);
        logic             hit;
        logic [SUM_W:0]   next_x;
        logic [SUM_W:0]   next_y;
        logic [SUM_W-1:0] quot;
        hit = in_window(p.blue,  bound_copy[REG_BLUE_LOW],  bound_copy[REG_BLUE_HIGH]) &&
              in_window(p.green, bound_copy[REG_GREEN_LOW], bound_copy[REG_GREEN_HIGH]) &&
              in_window(p.red,   bound_copy[REG_RED_LOW],   bound_copy[REG_RED_HIGH]) &&
              p.x < MAX_COLUMNS && p.y < MAX_ROWS;
        next_x = {1'b0, sum_x_acc} + p.x;
        next_y = {1'b0, sum_y_acc} + p.y;
        // a pixel that would overflow an accumulator is dropped whole
        if (hit && hits < COUNT_LIMIT && next_x <= SUM_LIMIT && next_y <= SUM_LIMIT)
        begin
            sum_x_acc = next_x[SUM_W-1:0];
            sum_y_acc = next_y[SUM_W-1:0];
            hits      = hits + 1'b1;
        end
        c = EMPTY_FRAME;
        if (!p.last)
            return 1'b0;
        c.found = hits != 0;
        if (hits != 0)
        begin
            quot = sum_x_acc / hits;
            c.cx = quot[COORD_W-1:0];
            quot = sum_y_acc / hits;
            c.cy = quot[COORD_W-1:0];
        end
        c.count   = hits;
        c.invalid = bound_copy[REG_BLUE_LOW]  > bound_copy[REG_BLUE_HIGH]  ||
                    bound_copy[REG_GREEN_LOW] > bound_copy[REG_GREEN_HIGH] ||
                    bound_copy[REG_RED_LOW]   > bound_copy[REG_RED_HIGH];
        sum_x_acc = '0;
        sum_y_acc = '0;
        hits      = '0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string field, input int want_v, input int got_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] frame result %0d, %s: expected %0d, got %0d",
                     $time, results_seen, field, want_v, got_v);
    endtask

    // pixel request with a random gap ahead of it, none while the flow is steady
    task automatic send_pixel(input pixel_t p, input logic typed, input centroid_t want);
        int        gap;
        centroid_t predicted;
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        blue_value  <= p.blue;
        green_value <= p.green;
        red_value   <= p.red;
        pixel_x     <= p.x;
        pixel_y     <= p.y;
        frame_end   <= p.last;
        push        <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (centroid_step(p, predicted))
            centroid_due.insert(centroid_due.size(), typed ? want : predicted);
        pixels_sent++;
        @(negedge clk);
    endtask

    // hold the sender until every frame result is back and the block is quiet
    task automatic wait_drained();
        push <= 1'b0;
        while (centroid_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    // write all bound registers, then the spare indexes with junk
    task automatic program_bounds(input bound_set_t v);
        cfg_write <= 1'b1;
        for (int i = 0; i < NUM_BOUNDS; i++)
        begin
            cfg_index     <= cfg_reg_t'(i);
            cfg_data      <= v[i];
            bound_copy[i] = v[i];
            @(negedge clk);
        end
        cfg_index <= REG_SPARE_A;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_index <= REG_SPARE_B;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // bound setting for one phase: fixed corner cases first, then random
    function automatic void pick_bounds(input int phase, output bound_set_t v);
        int lo;
        int hi;
        for (int ch = 0; ch < NUM_BOUNDS / 2; ch++)
        begin
            case (phase)
                0: begin lo = 0;   hi = 255; end
                1: begin lo = 255; hi = 0;   end
                2: begin lo = $urandom_range(0, 255); hi = lo; end
                3: begin
                    lo = (ch == 0) ? 60 : 0;
                    hi = (ch == 0) ? 40 : 255;
                end
                4: begin lo = $urandom_range(0, 253); hi = lo + 2; end
                5: begin
                    lo = (ch == 0) ? BLUE_LOW_RST  : RED_LOW_RST;
                    hi = (ch == 0) ? BLUE_HIGH_RST : RED_HIGH_RST;
                end
                default:
                begin
                    lo = $urandom_range(0, 200);
                    hi = lo + $urandom_range(2, 90);
                    if (hi > 255)
                        hi = 255;
                    if ($urandom_range(0, 5) == 0)
                    begin
                        lo = $urandom_range(0, 255);
                        hi = $urandom_range(0, 255);
                    end
                end
            endcase
            v[2 * ch]     = CFG_DATA_W'(lo);
            v[2 * ch + 1] = CFG_DATA_W'(hi);
        end
    endfunction

    // channel level: mostly inside the window, sometimes on a bound or anywhere
    function automatic logic [PIXEL_W-1:0] pick_level(input int lo, input int hi);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6 && hi > lo + 1)
            return PIXEL_W'($urandom_range(lo + 1, hi - 1));
        else if (roll == 6)
            return PIXEL_W'(lo);
        else if (roll == 7)
            return PIXEL_W'(hi);
        return PIXEL_W'($urandom_range(0, 255));
    endfunction

    // coordinate: half scattered, half clustered round the blob centre
    function automatic logic [COORD_W-1:0] pick_coord(input int centre);
        int v;
        if ($urandom_range(0, 1) == 0)
            return COORD_W'($urandom_range(0, 2047));
        v = centre - 40 + $urandom_range(0, 80);
        if (v < 0)
            v = 0;
        if (v > 2047)
            v = 2047;
        return COORD_W'(v);
    endfunction

    // result side: random pop stalls, check each frame result in order
    initial
    begin : result_sink
        int        stall;
        centroid_t got;
        centroid_t want;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            got = '{target_found, center_x, center_y, match_count, bounds_invalid};
            results_seen++;
            if (got.found)
                frames_found++;
            if (got.invalid)
                invalid_seen++;
            if (centroid_due.size() == 0)
                flag_mismatch("result with nothing expected", 0, 1);
            else
            begin
                want = centroid_due.pop_front();
                if (got.found !== want.found)
                    flag_mismatch("target_found", want.found, got.found);
                if (got.cx !== want.cx)
                    flag_mismatch("center_x", want.cx, got.cx);
                if (got.cy !== want.cy)
                    flag_mismatch("center_y", want.cy, got.cy);
                if (got.count !== want.count)
                    flag_mismatch("match_count", want.count, got.count);
                if (got.invalid !== want.invalid)
                    flag_mismatch("bounds_invalid", want.invalid, got.invalid);
            end
            @(negedge clk);
        end
    end

    // watchdog on cycles where no request moves on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no request moved for %0d cycles, %0d results pending",
                         $time, idle_cycles, centroid_due.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin : stimulus
        bound_set_t setting;
        pixel_t     p;
        int         sent;
        int         len;
        int         blob_x;
        int         blob_y;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table at the reset bounds
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        // random frames under each bound setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            pick_bounds(phase, setting);
            program_bounds(setting);
            sent = 0;
            while (sent < PHASE_PIXELS)
            begin
                case ($urandom_range(0, 11))
                    0, 1, 2: len = 1;
                    3:       len = $urandom_range(60, 120);
                    default: len = $urandom_range(2, 24);
                endcase
                if (len > PHASE_PIXELS - sent)
                    len = PHASE_PIXELS - sent;
                steady_flow = ($urandom_range(0, 5) == 0);
                blob_x = $urandom_range(0, 2047);
                blob_y = $urandom_range(0, 2047);
                for (int k = 0; k < len; k++)
                begin
                    p.blue  = pick_level(setting[REG_BLUE_LOW],  setting[REG_BLUE_HIGH]);
                    p.green = pick_level(setting[REG_GREEN_LOW], setting[REG_GREEN_HIGH]);
                    p.red   = pick_level(setting[REG_RED_LOW],   setting[REG_RED_HIGH]);
                    p.x     = pick_coord(blob_x);
                    p.y     = pick_coord(blob_y);
                    p.last  = (k == len - 1);
                    send_pixel(p, 1'b0, EMPTY_FRAME);
                end
                sent += len;
                // occasional pause until the result queue is empty
                if ($urandom_range(0, 14) == 0)
                begin
                    steady_flow = 1'b0;
                    wait_drained();
                end
            end
            steady_flow = 1'b0;
            wait_drained();
        end

        mismatches += centroid_due.size();
        $display("run covered %0d pixels under %0d bound settings (out-of-range indexes too)",
                 pixels_sent, PHASES + 1);
        $display("%0d frame results checked, %0d with a target, %0d with reversed bounds",
                 results_seen, frames_found, invalid_seen);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
